### src/ilid_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list package
// Shared sizes, command and status codes, state encoding and the control and
// status bundles between the list controller and the list datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ilid_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int CMD_W = 3;
  localparam int POS_W = 8;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int LEN_W = 8;
  // Wide enough to compare a position with the count without wrapping.
  localparam int CMP_W = POS_W + 1;

  localparam int IN_W  = 48;
  localparam int OUT_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET  = 3'd0,
    CMD_HEAD = 3'd1,
    CMD_TAIL = 3'd2,
    CMD_AT   = 3'd3,
    CMD_DEL  = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } st_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SH_RD,
    S_SH_WR,
    S_PUT_NEW,
    S_DEL_RD,
    S_DEL_WR,
    S_RESP
  } state_t;

  typedef enum logic [1:0] {
    RD_POS,
    RD_BELOW,
    RD_ABOVE
  } rd_sel_t;

  typedef enum logic {
    WR_SHIFT,
    WR_NEW
  } wr_sel_t;

  typedef struct packed {
    logic    load_item;
    logic    set_status;
    logic    ptr_load_ins;
    logic    ptr_load_del;
    logic    ptr_dec;
    logic    ptr_inc;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
  } ctl_t;

  typedef struct packed {
    logic get_ok;
    logic ins_ok;
    logic del_ok;
    logic ins_at_end;     // insert lands on the first free slot, nothing moves
    logic del_at_end;     // delete of the last entry, nothing moves
    logic shift_ins_last; // this write completes the gap at the insert point
    logic shift_del_last; // this write closes the gap up to the end
  } stat_t;

endpackage

`default_nettype wire

### src/indexed_list_insert_delete.sv
// ----------------------------------------------------------------------------
// Indexed list with insert and delete at a position
// Ordered list of up to 64 signed 32-bit entries with get, insert and delete.
// ----------------------------------------------------------------------------
// Each input beat is one command and gives exactly one result beat carrying
// the value read, a status and the list length after the command. A get, a
// rejected command, an unknown code or a delete of the last entry goes from
// the decision state straight to the result load, and an insert first writes
// the new entry. Every entry that an insert or delete moves adds a read state
// and a write state: entries live in a memory with one read and one write
// port, so each move is one registered read followed by one write. The result
// load waits while the previous result beat is still stalled. The next
// command is accepted the cycle after the load, while a result still waits on
// the output side. The list is empty after reset; no clearing pass.
`default_nettype none

module indexed_list_insert_delete (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  // in_tdata: cmd[2:0], position[10:3], item_value[42:11], zero fill above
  input  wire [ilid_pkg::IN_W-1:0]     in_tdata,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  // out_tdata: read_value[31:0], status[33:32], list_length[41:34], zeros above
  output logic [ilid_pkg::OUT_W-1:0]   out_tdata
);

  ilid_pkg::ctl_t             ctl;
  ilid_pkg::stat_t            stat;
  logic [ilid_pkg::VAL_W-1:0] read_value;
  logic [ilid_pkg::ST_W-1:0]  status;
  logic [ilid_pkg::LEN_W-1:0] list_length;

  ilid_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .ctl        (ctl)
  );

  ilid_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_cmd          (in_tdata[2:0]),
    .in_position     (in_tdata[10:3]),
    .in_item_value   (in_tdata[42:11]),
    .ctl             (ctl),
    .stat            (stat),
    .out_read_value  (read_value),
    .out_status      (status),
    .out_list_length (list_length)
  );

  assign out_tdata = {6'd0, list_length, status, read_value};

endmodule

`default_nettype wire

### src/ilid_datapath.sv
// ----------------------------------------------------------------------------
// Indexed list datapath
// Entry memory, entry count, move pointer, latched command and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_datapath (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire logic [ilid_pkg::CMD_W-1:0] in_cmd,
  input  wire logic [ilid_pkg::POS_W-1:0] in_position,
  input  wire logic [ilid_pkg::VAL_W-1:0] in_item_value,
  input  wire ilid_pkg::ctl_t           ctl,
  output ilid_pkg::stat_t               stat,
  output logic [ilid_pkg::VAL_W-1:0]    out_read_value,
  output logic [ilid_pkg::ST_W-1:0]     out_status,
  output logic [ilid_pkg::LEN_W-1:0]    out_list_length
);

  logic [ilid_pkg::CMD_W-1:0] op_r;
  logic [ilid_pkg::POS_W-1:0] pos_r;
  logic [ilid_pkg::VAL_W-1:0] val_r;
  logic [ilid_pkg::ST_W-1:0]  st_r;
  logic [ilid_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ilid_pkg::CNT_W-1:0] k_r, k_nxt;
  logic [ilid_pkg::VAL_W-1:0] rdata_r;
  logic [ilid_pkg::VAL_W-1:0] mem [0:ilid_pkg::CAPACITY-1];

  logic [ilid_pkg::VAL_W-1:0] rv_r;
  logic [ilid_pkg::ST_W-1:0]  rst_r;
  logic [ilid_pkg::LEN_W-1:0] len_r;

  logic [ilid_pkg::CMP_W-1:0] cnt_ext, pos_ext, k_ext, ins_pos_ext;
  logic [ilid_pkg::CNT_W-1:0] k_below, k_above;
  logic [ilid_pkg::IDX_W-1:0] rd_addr, wr_addr;
  logic [ilid_pkg::VAL_W-1:0] wr_data;
  logic                       in_range, ins_range_bad, full;
  logic [ilid_pkg::ST_W-1:0]  st_code;

  always_comb begin
    cnt_ext  = ilid_pkg::CMP_W'(cnt_r);
    pos_ext  = ilid_pkg::CMP_W'(pos_r);
    k_ext    = ilid_pkg::CMP_W'(k_r);
    in_range = pos_ext < cnt_ext;
    full     = cnt_r >= ilid_pkg::CNT_W'(ilid_pkg::CAPACITY);

    case (op_r)
      ilid_pkg::CMD_HEAD: ins_pos_ext = '0;
      ilid_pkg::CMD_TAIL: ins_pos_ext = cnt_ext;
      default:            ins_pos_ext = pos_ext;
    endcase
    ins_range_bad = (op_r == ilid_pkg::CMD_AT) && (pos_ext > cnt_ext);

    stat    = '0;
    st_code = ilid_pkg::ST_DONE;
    case (op_r)
      ilid_pkg::CMD_GET: begin
        stat.get_ok = in_range;
        st_code     = in_range ? ilid_pkg::ST_DONE : ilid_pkg::ST_RANGE;
      end
      ilid_pkg::CMD_HEAD, ilid_pkg::CMD_TAIL, ilid_pkg::CMD_AT: begin
        // The range check takes precedence over the capacity check.
        if (ins_range_bad) begin
          st_code = ilid_pkg::ST_RANGE;
        end else if (full) begin
          st_code = ilid_pkg::ST_FULL;
        end else begin
          stat.ins_ok = 1'b1;
        end
      end
      ilid_pkg::CMD_DEL: begin
        stat.del_ok = in_range;
        st_code     = in_range ? ilid_pkg::ST_DONE : ilid_pkg::ST_RANGE;
      end
      default: st_code = ilid_pkg::ST_DONE;
    endcase

    stat.ins_at_end     = ins_pos_ext == cnt_ext;
    stat.del_at_end     = (pos_ext + ilid_pkg::CMP_W'(1)) == cnt_ext;
    stat.shift_ins_last = k_ext == (ins_pos_ext + ilid_pkg::CMP_W'(1));
    stat.shift_del_last = (k_ext + ilid_pkg::CMP_W'(2)) == cnt_ext;

    k_below = k_r - ilid_pkg::CNT_W'(1);
    k_above = k_r + ilid_pkg::CNT_W'(1);
    case (ctl.rd_sel)
      ilid_pkg::RD_BELOW: rd_addr = k_below[ilid_pkg::IDX_W-1:0];
      ilid_pkg::RD_ABOVE: rd_addr = k_above[ilid_pkg::IDX_W-1:0];
      default:            rd_addr = pos_r[ilid_pkg::IDX_W-1:0];
    endcase
    if (ctl.wr_sel == ilid_pkg::WR_NEW) begin
      wr_addr = ins_pos_ext[ilid_pkg::IDX_W-1:0];
      wr_data = val_r;
    end else begin
      wr_addr = k_r[ilid_pkg::IDX_W-1:0];
      wr_data = rdata_r;
    end

    k_nxt = k_r;
    if (ctl.ptr_load_ins) begin
      k_nxt = cnt_r;
    end else if (ctl.ptr_load_del) begin
      k_nxt = ilid_pkg::CNT_W'(pos_r);
    end else if (ctl.ptr_dec) begin
      k_nxt = k_below;
    end else if (ctl.ptr_inc) begin
      k_nxt = k_above;
    end

    cnt_nxt = cnt_r;
    if (ctl.cnt_inc) begin
      cnt_nxt = cnt_r + ilid_pkg::CNT_W'(1);
    end else if (ctl.cnt_dec) begin
      cnt_nxt = cnt_r - ilid_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    if (ctl.load_item) begin
      op_r  <= in_cmd;
      pos_r <= in_position;
      val_r <= in_item_value;
    end
    if (ctl.set_status) begin
      st_r <= st_code;
    end
    if (ctl.out_load) begin
      // Only a successful get returns stored data; everything else gives -1.
      rv_r  <= (op_r == ilid_pkg::CMD_GET && st_r == ilid_pkg::ST_DONE) ? rdata_r : '1;
      rst_r <= st_r;
      len_r <= ilid_pkg::LEN_W'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign out_read_value  = rv_r;
  assign out_status      = rst_r;
  assign out_list_length = len_r;

endmodule

`default_nettype wire

### src/ilid_ctrl.sv
// ----------------------------------------------------------------------------
// Indexed list controller
// Sequences each command: decision, entry moves one at a time, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  wire                  out_tready,
  input  wire ilid_pkg::stat_t stat,
  output ilid_pkg::ctl_t       ctl
);

  ilid_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ilid_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    ctl           = '0;
    ctl.rd_sel    = ilid_pkg::RD_POS;
    ctl.wr_sel    = ilid_pkg::WR_SHIFT;
    state_nxt     = state_r;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;

    case (state_r)
      ilid_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.load_item = 1'b1;
          state_nxt     = ilid_pkg::S_DECIDE;
        end
      end
      ilid_pkg::S_DECIDE: begin
        ctl.set_status = 1'b1;
        state_nxt      = ilid_pkg::S_RESP;
        if (stat.get_ok) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = ilid_pkg::RD_POS;
        end else if (stat.ins_ok) begin
          ctl.ptr_load_ins = 1'b1;
          state_nxt = stat.ins_at_end ? ilid_pkg::S_PUT_NEW : ilid_pkg::S_SH_RD;
        end else if (stat.del_ok) begin
          ctl.ptr_load_del = 1'b1;
          if (stat.del_at_end) begin
            ctl.cnt_dec = 1'b1;
          end else begin
            state_nxt = ilid_pkg::S_DEL_RD;
          end
        end
      end
      ilid_pkg::S_SH_RD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = ilid_pkg::RD_BELOW;
        state_nxt  = ilid_pkg::S_SH_WR;
      end
      ilid_pkg::S_SH_WR: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_sel  = ilid_pkg::WR_SHIFT;
        ctl.ptr_dec = 1'b1;
        state_nxt   = stat.shift_ins_last ? ilid_pkg::S_PUT_NEW : ilid_pkg::S_SH_RD;
      end
      ilid_pkg::S_PUT_NEW: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_sel  = ilid_pkg::WR_NEW;
        ctl.cnt_inc = 1'b1;
        state_nxt   = ilid_pkg::S_RESP;
      end
      ilid_pkg::S_DEL_RD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = ilid_pkg::RD_ABOVE;
        state_nxt  = ilid_pkg::S_DEL_WR;
      end
      ilid_pkg::S_DEL_WR: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_sel  = ilid_pkg::WR_SHIFT;
        ctl.ptr_inc = 1'b1;
        if (stat.shift_del_last) begin
          ctl.cnt_dec = 1'b1;
          state_nxt   = ilid_pkg::S_RESP;
        end else begin
          state_nxt = ilid_pkg::S_DEL_RD;
        end
      end
      ilid_pkg::S_RESP: begin
        // The result register frees up either empty or on the beat leaving it.
        if (!out_valid_r || out_tready) begin
          ctl.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ilid_pkg::S_IDLE;
        end
      end
      default: state_nxt = ilid_pkg::S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

### src/ilid_checker.sv
// ----------------------------------------------------------------------------
// Indexed list port checker
// Watches the ports of the indexed list block and flags illegal behaviour.
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_tvalid,
  input wire                        in_tready,
  input wire [ilid_pkg::IN_W-1:0]   in_tdata,
  input wire                        out_tvalid,
  input wire                        out_tready,
  input wire [ilid_pkg::OUT_W-1:0]  out_tdata
);

  // A result beat that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // One command at a time: the cycle after an accepted beat is always busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second command taken while the first is still in work");

  // Status code three is never produced and the padding stays clear.
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[33:32] != 2'd3 && out_tdata[47:42] == 6'd0)
    else $error("illegal status or non-zero padding");

  // The reported length never exceeds the capacity.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[41:34] <= ilid_pkg::LEN_W'(ilid_pkg::CAPACITY))
    else $error("list length beyond capacity");

  // No result is offered straight out of reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind indexed_list_insert_delete ilid_checker u_ilid_checker (.*);

`default_nettype wire

### verif/indexed_list_insert_delete_tb.sv
// ----------------------------------------------------------------------------
// Indexed list regression bench
// Drives get, insert and delete commands into the list and checks every result
// beat against a behavioural copy of the list kept inside the bench. Both
// stream sides stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam logic [ilid_pkg::CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [ilid_pkg::CMD_W-1:0] CMD_LAST_CODE    = 3'd7;
  localparam int                         STALL_LIMIT      = 2000;
  localparam int                         SETTLE_CYCLES    = 150;

  typedef struct packed {
    logic [ilid_pkg::VAL_W-1:0] read_value;
    logic [ilid_pkg::ST_W-1:0]  status;
    logic [ilid_pkg::LEN_W-1:0] list_length;
  } list_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [ilid_pkg::IN_W-1:0]  in_tdata = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [ilid_pkg::OUT_W-1:0] out_tdata;

  // Behavioural copy of the list, updated as each command beat is accepted.
  logic [ilid_pkg::VAL_W-1:0] list_entries [ilid_pkg::CAPACITY];
  int                         list_len = 0;
  list_result_t               expected_results [$];

  int                error_count = 0;
  int                quiet_cycles = 0;
  int                ready_hold = 0;
  bit                idle_off = 1'b0;

  indexed_list_insert_delete dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic list_result_t apply_list_cmd(input logic [ilid_pkg::CMD_W-1:0] cmd,
                                                  input logic [ilid_pkg::POS_W-1:0] pos,
                                                  input logic [ilid_pkg::VAL_W-1:0] val);
    list_result_t r;
    int           at;
    r.read_value = '1;
    r.status     = ilid_pkg::ST_DONE;
    case (cmd)
      ilid_pkg::CMD_GET: begin
        if (pos < list_len) r.read_value = list_entries[pos];
        else r.status = ilid_pkg::ST_RANGE;
      end
      ilid_pkg::CMD_HEAD, ilid_pkg::CMD_TAIL, ilid_pkg::CMD_AT: begin
        at = (cmd == ilid_pkg::CMD_HEAD) ? 0 :
             (cmd == ilid_pkg::CMD_TAIL) ? list_len : int'(pos);
        // The range check takes precedence over the full check.
        if (at > list_len) begin
          r.status = ilid_pkg::ST_RANGE;
        end else if (list_len >= ilid_pkg::CAPACITY) begin
          r.status = ilid_pkg::ST_FULL;
        end else begin
          for (int k = list_len; k > at; k--) list_entries[k] = list_entries[k-1];
          list_entries[at] = val;
          list_len++;
        end
      end
      ilid_pkg::CMD_DEL: begin
        if (pos < list_len) begin
          for (int k = pos; k + 1 < list_len; k++) list_entries[k] = list_entries[k+1];
          list_len--;
        end else begin
          r.status = ilid_pkg::ST_RANGE;
        end
      end
      default: ;
    endcase
    r.list_length = list_len[ilid_pkg::LEN_W-1:0];
    return r;
  endfunction

  // Called at a rising edge; leaves tvalid high so that a following beat
  // without a gap needs no second assignment in the same step.
  task automatic send_cmd(input logic [ilid_pkg::CMD_W-1:0] cmd,
                          input logic [ilid_pkg::POS_W-1:0] pos,
                          input logic [ilid_pkg::VAL_W-1:0] val);
    int gap;
    gap = idle_off ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {{(ilid_pkg::IN_W - ilid_pkg::CMD_W - ilid_pkg::POS_W - ilid_pkg::VAL_W){1'b0}},
                  val, pos, cmd};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(apply_list_cmd(cmd, pos, val));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic send_random(input bit grow);
    int                         r;
    logic [ilid_pkg::CMD_W-1:0] cmd;
    logic [ilid_pkg::POS_W-1:0] pos;
    r = $urandom_range(0, 99);
    if (r < 5) cmd = ilid_pkg::CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
    else if (r < 10) cmd = ilid_pkg::CMD_W'($urandom_range(0, CMD_LAST_CODE));
    else if (r < 40) cmd = ilid_pkg::CMD_GET;
    else if (r < (grow ? 85 : 55))
      cmd = ilid_pkg::CMD_W'($urandom_range(ilid_pkg::CMD_HEAD, ilid_pkg::CMD_AT));
    else cmd = ilid_pkg::CMD_DEL;
    if ($urandom_range(0, 4) == 0) pos = ilid_pkg::POS_W'($urandom_range(0, 255));
    else pos = ilid_pkg::POS_W'($urandom_range(0, list_len));
    send_cmd(cmd, pos, $urandom);
  endtask

  task automatic test_empty_list();
    send_cmd(ilid_pkg::CMD_GET, 8'd0, $urandom);
    send_cmd(ilid_pkg::CMD_GET, 8'd255, $urandom);
    send_cmd(ilid_pkg::CMD_DEL, 8'd0, $urandom);
    send_cmd(ilid_pkg::CMD_AT, 8'd1, $urandom);
    for (int c = CMD_FIRST_UNUSED; c <= CMD_LAST_CODE; c++)
      send_cmd(ilid_pkg::CMD_W'(c), ilid_pkg::POS_W'($urandom), $urandom);
  endtask

  task automatic test_basic_ops();
    send_cmd(ilid_pkg::CMD_HEAD, 8'd0, 32'h8000_0000);
    send_cmd(ilid_pkg::CMD_TAIL, 8'd0, 32'h7fff_ffff);
    send_cmd(ilid_pkg::CMD_AT, 8'd1, 32'h0000_0000);
    // A position equal to the length appends.
    send_cmd(ilid_pkg::CMD_AT, 8'd3, 32'hffff_ffff);
    for (int p = 0; p < 4; p++) send_cmd(ilid_pkg::CMD_GET, ilid_pkg::POS_W'(p), $urandom);
    send_cmd(ilid_pkg::CMD_AT, 8'd255, $urandom);
    send_cmd(ilid_pkg::CMD_DEL, 8'd1, $urandom);
    send_cmd(ilid_pkg::CMD_DEL, 8'd2, $urandom);
    send_cmd(ilid_pkg::CMD_DEL, 8'd255, $urandom);
    send_cmd(ilid_pkg::CMD_GET, 8'd2, $urandom);
    send_cmd(ilid_pkg::CMD_GET, 8'd1, $urandom);
  endtask

  task automatic test_full_list();
    idle_off <= 1'b1;
    while (list_len < ilid_pkg::CAPACITY)
      send_cmd(ilid_pkg::CMD_W'($urandom_range(ilid_pkg::CMD_HEAD, ilid_pkg::CMD_AT)),
               ilid_pkg::POS_W'($urandom_range(0, list_len)), $urandom);
    idle_off <= 1'b0;
    send_cmd(ilid_pkg::CMD_HEAD, 8'd0, $urandom);
    send_cmd(ilid_pkg::CMD_TAIL, 8'd0, $urandom);
    send_cmd(ilid_pkg::CMD_AT, ilid_pkg::POS_W'(ilid_pkg::CAPACITY), $urandom);
    send_cmd(ilid_pkg::CMD_AT, ilid_pkg::POS_W'(ilid_pkg::CAPACITY + 1), $urandom);
    send_cmd(ilid_pkg::CMD_AT, 8'd255, $urandom);
    send_cmd(ilid_pkg::CMD_GET, ilid_pkg::POS_W'(ilid_pkg::CAPACITY - 1), $urandom);
    send_cmd(ilid_pkg::CMD_GET, ilid_pkg::POS_W'(ilid_pkg::CAPACITY), $urandom);
    // Longest moves in both directions.
    send_cmd(ilid_pkg::CMD_DEL, 8'd0, $urandom);
    send_cmd(ilid_pkg::CMD_HEAD, 8'd0, $urandom);
    send_cmd(ilid_pkg::CMD_GET, 8'd0, $urandom);
    drain_results();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      idle_off <= (phase == 2);
      for (int n = 0; n < 80; n++) send_random(phase % 2 == 0);
      if (phase == 1) drain_results();
    end
    idle_off <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (idle_off) begin
      out_tready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      ready_hold <= pick_gap();
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    list_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with no command outstanding, actual %h",
                 $time, out_tdata);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("read_value", exp_r.read_value, out_tdata[31:0]);
        check_field("status", 32'(exp_r.status), 32'(out_tdata[33:32]));
        check_field("list_length", 32'(exp_r.list_length), 32'(out_tdata[41:34]));
      end
    end
  end

  // Ends the run if neither side moves a beat for far longer than the slowest
  // command plus the longest stalls.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("indexed_list_insert_delete regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_basic_ops();
    test_full_list();
    test_random_traffic();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("indexed_list_insert_delete regression: pass");
    end else begin
      $display("indexed_list_insert_delete regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
